[rtl/core/ffve_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffve_pkg
// Shared types and constants of the form field value extractor.
// ----------------------------------------------------------------------------
package ffve_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int COUNT_BITS    = 12;

	localparam int KEY_LEN_W = 5;
	localparam int LIMIT_W   = 12;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] CHAR_AMP = 8'h26;
	localparam logic [7:0] CHAR_EQ  = 8'h3D;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VAL_LIMIT = 2'd3;

	typedef enum logic [1:0] {
		PH_MATCH = 2'd0,
		PH_SKIP  = 2'd1,
		PH_VALUE = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [63:0]          key_low;
		logic [63:0]          key_high;
		logic [KEY_LEN_W-1:0] key_len;
		logic [LIMIT_W-1:0]   val_limit;
	} cfg_t;

	typedef struct packed {
		phase_t                phase;
		logic [KEY_LEN_W-1:0]  name_pos;
		logic [COUNT_BITS-1:0] val_count;
	} body_state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       found;
		logic       final_res;
	} result_t;

endpackage

[rtl/core/ffve_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffve_cfg
// Configuration register file: key bytes, key length and value limit.
// ----------------------------------------------------------------------------
module ffve_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ffve_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffve_pkg::CFG_W-1:0]       cfg_data,
	output ffve_pkg::cfg_t                   cfg
);
	import ffve_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_low   <= '0;
			cfg_q.key_high  <= '0;
			cfg_q.key_len   <= KEY_LEN_W'(1);
			cfg_q.val_limit <= LIMIT_W'(255);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_LOW:   cfg_q.key_low   <= cfg_data;
				CFG_KEY_HIGH:  cfg_q.key_high  <= cfg_data;
				CFG_KEY_LEN:   cfg_q.key_len   <= cfg_data[KEY_LEN_W-1:0];
				CFG_VAL_LIMIT: cfg_q.val_limit <= cfg_data[LIMIT_W-1:0];
				default:       ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/ffve_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffve_step
// Per-byte parser step: next body state and the result of one byte.
// ----------------------------------------------------------------------------
module ffve_step (
	input  ffve_pkg::cfg_t        cfg,
	input  ffve_pkg::body_state_t cur,
	input  logic [7:0]            body_byte,
	input  logic                  body_end,
	output ffve_pkg::body_state_t nxt,
	output ffve_pkg::result_t     res
);
	import ffve_pkg::*;

	localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
	localparam logic [CMP_W-1:0] CMAX = CMP_W'((1 << COUNT_BITS) - 1);

	logic [KEY_LEN_W-1:0]  klen;
	logic [CMP_W-1:0]      lim;
	logic [127:0]          key_all;
	logic [7:0]            key_byte;
	logic                  last;
	logic                  emit;
	body_state_t           upd;

	always_comb begin
		klen = (cfg.key_len > KEY_LEN_W'(MAX_KEY_BYTES)) ? KEY_LEN_W'(MAX_KEY_BYTES)
			: cfg.key_len;
		lim = (CMP_W'(cfg.val_limit) > CMAX) ? CMAX : CMP_W'(cfg.val_limit);
		key_all  = {cfg.key_high, cfg.key_low};
		key_byte = key_all[cur.name_pos[3:0]*8 +: 8];
		last = body_end || (body_byte == 8'h00);
		emit = 1'b0;
		upd  = cur;

		if (body_byte != 8'h00) begin
			unique case (cur.phase)
				PH_MATCH: begin
					if (body_byte == CHAR_AMP) begin
						upd.name_pos = '0;
					end else if (cur.name_pos < klen) begin
						if (body_byte == key_byte)
							upd.name_pos = cur.name_pos + KEY_LEN_W'(1);
						else
							upd.phase = PH_SKIP;
					end else if (body_byte == CHAR_EQ) begin
						upd.phase     = PH_VALUE;
						upd.val_count = '0;
					end else begin
						upd.phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (body_byte == CHAR_AMP) begin
						upd.phase    = PH_MATCH;
						upd.name_pos = '0;
					end
				end
				PH_VALUE: begin
					if (body_byte == CHAR_AMP) begin
						upd.phase = PH_DONE;
					end else if (CMP_W'(cur.val_count) < lim) begin
						emit          = 1'b1;
						upd.val_count = cur.val_count + COUNT_BITS'(1);
					end
				end
				default: ;
			endcase
		end

		res.valid      = emit || last;
		res.value_byte = emit ? body_byte : 8'h00;
		res.byte_valid = emit;
		res.found      = (upd.phase == PH_VALUE) || (upd.phase == PH_DONE);
		res.final_res  = last;

		if (last) begin
			nxt.phase     = PH_MATCH;
			nxt.name_pos  = '0;
			nxt.val_count = '0;
		end else begin
			nxt = upd;
		end
	end

endmodule

[rtl/core/form_field_value_extractor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_field_value_extractor_core
// Finds a configured key in a form-encoded body and streams out its value.
// ----------------------------------------------------------------------------
// Body bytes enter on the slave stream, one per beat, with tlast on the last
// byte; a zero byte also ends the body. The block looks for the first segment
// (start of body or after '&') whose name equals the configured key and is
// followed by '='. Bytes of that value, up to value_limit, leave on the master
// stream with tuser[0] (byte_valid) and tuser[1] (found) set. At the end of
// each body one closing beat carries tlast; its tuser[1] tells whether the key
// was seen. No percent-decoding is done. Throughput is one body byte per clock
// while the master keeps up; an input register and an output register sit
// around a combinational parser step, and each result passes through both.
// The output register lets the next byte be taken while a result waits; a
// stalled master stops intake only once the input register also holds a byte
// with a pending result. Configuration registers are written via cfg_we/
// cfg_index/cfg_data and must only change while the block is idle.
// ----------------------------------------------------------------------------
module form_field_value_extractor_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write port
	input  logic                           cfg_we,
	input  logic [ffve_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffve_pkg::CFG_W-1:0]     cfg_data,
	// body stream in
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] body_byte
	input  logic                           s_tlast,   // body_end
	// value stream out
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] value_byte
	output logic [1:0]                     m_tuser,   // [0] byte_valid, [1] found
	output logic                           m_tlast    // final_res
);
	import ffve_pkg::*;

	cfg_t        cfg;
	body_state_t state_q;
	body_state_t state_nxt;
	result_t     res;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// output stage
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_bv_q;
	logic        out_found_q;
	logic        out_last_q;

	logic        out_free;
	logic        advance;

	ffve_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ffve_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.body_byte (byte_s1),
		.body_end  (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	// A byte in s1 retires when it has no result or the output slot is free.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!res.valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// parser state commits only when the s1 byte retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_MATCH;
			state_q.name_pos  <= '0;
			state_q.val_count <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_byte_q  <= res.value_byte;
			out_bv_q    <= res.byte_valid;
			out_found_q <= res.found;
			out_last_q  <= res.final_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_found_q, out_bv_q};
	assign m_tlast  = out_last_q;

endmodule

[tb/tb_form_field_value_extractor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_form_field_value_extractor_core
// Self-checking bench for the form field value extractor: form-encoded bodies
// stream in, and every value beat and closing beat is checked against a
// cycle-free software model of the key match and value extraction.
// ----------------------------------------------------------------------------
// Flow:
//   - directed bodies: reset settings, a clean hit, limit overflow, mismatching
//     names, lone '&', extreme bytes, zero byte as body end, empty value,
//     empty key
//   - back-pressure: a long receiver hold-off while a long value keeps coming,
//     a pause until the block has drained, then a shorter hold-off with gaps
//   - random bodies under many key/limit settings, mostly well-formed
//     segments, with noise and broken names mixed in
// Inputs change on the falling edge; beats are taken on the rising edge.
// ----------------------------------------------------------------------------
module tb_form_field_value_extractor_core;
	import ffve_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int DRAIN_CYCLES = 8;       // two-stage pipe plus margin
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 1550;
	localparam int REPORT_MAX   = 10;

	// one expected beat on the value stream
	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       found;
		logic       final_res;
	} value_beat_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;   // [7:0] body_byte
	logic                 s_tlast   = 1'b0; // body_end
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;          // [7:0] value_byte
	logic [1:0]           m_tuser;          // [0] byte_valid, [1] found
	logic                 m_tlast;          // final_res

	// shadow of the config registers
	logic [63:0]          key_lo_m    = '0;
	logic [63:0]          key_hi_m    = '0;
	logic [KEY_LEN_W-1:0] key_len_m   = 5'd1;
	logic [LIMIT_W-1:0]   val_limit_m = 12'd255;

	// shadow of the per-body parser state
	phase_t                phase_m     = PH_MATCH;
	logic [KEY_LEN_W-1:0]  name_pos_m  = '0;
	logic [COUNT_BITS-1:0] val_count_m = '0;

	value_beat_t value_beat_q[$];
	value_beat_t due_beat;

	// idle control for both sides
	logic in_idle  = 1'b1;
	logic out_idle = 1'b1;
	int   rx_stall = 0;
	int   rx_hold  = 0;

	int mismatch_count   = 0;
	int items_sent       = 0;
	int value_bytes_seen = 0;
	int finals_seen      = 0;
	int found_finals     = 0;
	int cycle_count      = 0;

	form_field_value_extractor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------------

	// key byte at a name position, first byte in the low bits of the low word
	function automatic logic [7:0] key_char(input int pos);
		logic [63:0] word;
		word = (pos < 8) ? key_lo_m : key_hi_m;
		return word[(pos % 8) * 8 +: 8];
	endfunction

	// Advance the shadow parser by one accepted body byte and queue the beat
	// it produces, if any. A zero byte closes the body regardless of tlast.
	function automatic void parse_body_byte(input logic [7:0] b, input logic close);
		int          klen;
		logic        emit;
		logic        body_over;
		value_beat_t beat;
		klen      = (key_len_m > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len_m);
		emit      = 1'b0;
		body_over = close;
		if (b == 8'h00) begin
			body_over = 1'b1;
		end else begin
			case (phase_m)
				PH_MATCH: begin
					// '&' restarts the name even where the key holds '&'
					if (b == CHAR_AMP) begin
						name_pos_m = '0;
					end else if (name_pos_m < klen) begin
						if (b == key_char(name_pos_m))
							name_pos_m = name_pos_m + 1'b1;
						else
							phase_m = PH_SKIP;
					end else if (b == CHAR_EQ) begin
						phase_m     = PH_VALUE;
						val_count_m = '0;
					end else begin
						phase_m = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (b == CHAR_AMP) begin
						phase_m    = PH_MATCH;
						name_pos_m = '0;
					end
				end
				PH_VALUE: begin
					if (b == CHAR_AMP) begin
						phase_m = PH_DONE;
					end else if (val_count_m < val_limit_m) begin
						emit        = 1'b1;
						val_count_m = val_count_m + 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (emit || body_over) begin
			beat.value_byte = emit ? b : 8'h00;
			beat.byte_valid = emit;
			beat.found      = (phase_m == PH_VALUE) || (phase_m == PH_DONE);
			beat.final_res  = body_over;
			value_beat_q.push_back(beat);
		end
		if (body_over) begin
			phase_m     = PH_MATCH;
			name_pos_m  = '0;
			val_count_m = '0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// one body byte on the slave stream, with an optional random gap first
	task automatic send_beat(input logic [7:0] b, input logic close);
		int gap;
		gap = in_idle ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= close;
		do @(posedge clk); while (!s_tready);
		parse_body_byte(b, close);
		items_sent++;
	endtask

	task automatic send_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], close && (i == s.len() - 1));
	endtask

	// Stop offering, let every expected beat come out, then give bytes that
	// produce nothing time to leave the pipe.
	task automatic wait_for_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (value_beat_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_KEY_LOW:   key_lo_m    = data;
			CFG_KEY_HIGH:  key_hi_m    = data;
			CFG_KEY_LEN:   key_len_m   = data[KEY_LEN_W-1:0];
			CFG_VAL_LIMIT: val_limit_m = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// all four registers, back to back, only once the block is idle
	task automatic apply_settings(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] len_word, input logic [63:0] lim_word);
		wait_for_quiet();
		write_cfg(CFG_KEY_LOW, lo);
		write_cfg(CFG_KEY_HIGH, hi);
		write_cfg(CFG_KEY_LEN, len_word);
		write_cfg(CFG_VAL_LIMIT, lim_word);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Body builders
	// ------------------------------------------------------------------------

	// nonzero byte that is neither a separator nor '='
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		if (c == CHAR_AMP || c == CHAR_EQ)
			c = 8'h76;
		return c;
	endfunction

	function automatic void add_key(ref logic [7:0] q[$], input int n);
		for (int i = 0; i < n; i++)
			q.push_back(key_char(i));
	endfunction

	// '=' then a value; mostly short, now and then past any small limit
	function automatic void add_value(ref logic [7:0] q[$]);
		int n;
		q.push_back(CHAR_EQ);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
		for (int i = 0; i < n; i++)
			q.push_back(plain_char());
	endfunction

	task automatic send_random_body();
		logic [7:0] body[$];
		int         klen;
		int         nseg;
		int         n;
		logic       close;
		klen = (key_len_m > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len_m);
		nseg = $urandom_range(1, 4);
		if ($urandom_range(0, 9) == 0)
			body.push_back(CHAR_AMP);
		for (int s = 0; s < nseg; s++) begin
			if (s > 0) begin
				body.push_back(CHAR_AMP);
				if ($urandom_range(0, 9) == 0)
					body.push_back(CHAR_AMP);
			end
			case ($urandom_range(0, 9))
				4, 5: begin
					// some other name
					n = $urandom_range(1, 6);
					repeat (n) body.push_back(plain_char());
					add_value(body);
				end
				6: begin
					// truncated key
					if (klen > 1)
						add_key(body, $urandom_range(1, klen - 1));
					else
						add_key(body, klen);
					add_value(body);
				end
				7: begin
					// key with a trailing extra byte
					add_key(body, klen);
					body.push_back(plain_char());
					add_value(body);
				end
				8: add_key(body, klen);   // key, no '='
				9: begin
					// raw noise, zero and separators included
					n = $urandom_range(1, 8);
					repeat (n) body.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					add_key(body, klen);
					add_value(body);
				end
			endcase
		end
		// close mostly by tlast, sometimes by a trailing zero byte
		if (body.size() == 0 || $urandom_range(0, 19) >= 16) begin
			body.push_back(8'h00);
			close = $urandom_range(0, 1);
		end else begin
			close = 1'b1;
		end
		for (int i = 0; i < body.size(); i++)
			send_beat(body[i], close && (i == body.size() - 1));
	endtask

	// ------------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------------

	// a hold-off request from a test wins over the per-beat stall
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall = rx_stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (value_beat_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%0t: unexpected beat data=%02h user=%b last=%b",
						$time, m_tdata, m_tuser, m_tlast);
			end else begin
				due_beat = value_beat_q.pop_front();
				if (m_tdata !== due_beat.value_byte || m_tuser[0] !== due_beat.byte_valid ||
						m_tuser[1] !== due_beat.found || m_tlast !== due_beat.final_res) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: exp data/bv/found/last=%02h/%b/%b/%b got %02h/%b/%b/%b",
							$time, due_beat.value_byte, due_beat.byte_valid, due_beat.found,
							due_beat.final_res, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
				end
				if (due_beat.byte_valid)
					value_bytes_seen++;
				if (due_beat.final_res) begin
					finals_seen++;
					if (due_beat.found)
						found_finals++;
				end
			end
			rx_stall = out_idle ? $urandom_range(0, 8) : 0;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_directed_cases();
		in_idle  = 1'b1;
		out_idle = 1'b1;
		// reset settings: key is one zero byte, which no body byte can match
		send_text("a=b", 1'b1);
		// key "id", keep at most three value bytes
		apply_settings(64'h6469, 64'h0, 64'd2, 64'd3);
		send_text("id=ab", 1'b1);        // last value byte is also the closing beat
		send_text("x&id=9999", 1'b0);    // skip a wrong name, drop the excess byte
		send_beat(8'h00, 1'b0);          // zero byte ends the body
		send_text("&", 1'b1);            // lone separator
		send_beat(8'hFF, 1'b1);          // all-ones byte
		send_beat(8'h00, 1'b1);          // zero byte carrying tlast too
		send_text("id=&k", 1'b1);        // empty value, tail ignored, found stays
		// empty key: a segment opening with '=' is a hit
		apply_settings(64'h0, 64'h0, 64'd0, 64'd3);
		send_text("=v", 1'b1);
	endtask

	task automatic test_backpressure();
		// key "k", widest limit
		apply_settings(64'h6B, {$urandom, $urandom}, {59'h0, 5'd1}, {52'h0, 12'd4095});
		in_idle  = 1'b0;
		out_idle = 1'b0;
		// receiver holds off while a long value keeps coming
		rx_hold = 150;
		send_text("k=", 1'b0);
		for (int i = 0; i < 48; i++)
			send_beat(plain_char(), i == 47);
		// let everything out before going on
		wait_for_quiet();
		in_idle  = 1'b1;
		out_idle = 1'b1;
		rx_hold  = 80;
		send_text("k=", 1'b0);
		for (int i = 0; i < 20; i++)
			send_beat(plain_char(), 1'b0);
		send_text("&k=zz", 1'b1);
	endtask

	task automatic test_random_bodies();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] len_word;
		logic [63:0] lim_word;
		logic [7:0]  c;
		int          start_items;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			// key bytes: mostly letters, with '&', '=' and raw bytes mixed in
			lo = '0;
			hi = '0;
			if ($urandom_range(0, 9) == 0) begin
				lo = '1;
				hi = '1;
			end else begin
				for (int i = 0; i < 16; i++) begin
					case ($urandom_range(0, 15))
						0: c = CHAR_AMP;
						1: c = CHAR_EQ;
						2: c = 8'($urandom_range(0, 255));
						default: c = 8'h61 + 8'($urandom_range(0, 25));
					endcase
					if (i < 8)
						lo[i * 8 +: 8] = c;
					else
						hi[(i - 8) * 8 +: 8] = c;
				end
			end
			// upper bits are don't-care and get random junk
			len_word = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: len_word[KEY_LEN_W-1:0] = 5'd0;
				1: len_word[KEY_LEN_W-1:0] = 5'd1;
				2: len_word[KEY_LEN_W-1:0] = 5'd16;
				3: len_word[KEY_LEN_W-1:0] = 5'($urandom_range(17, 31));   // clamped to 16
				default: len_word[KEY_LEN_W-1:0] = 5'($urandom_range(1, 5));
			endcase
			lim_word = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: lim_word[LIMIT_W-1:0] = 12'd0;
				1: lim_word[LIMIT_W-1:0] = 12'd4095;
				2: lim_word[LIMIT_W-1:0] = 12'd1;
				default: lim_word[LIMIT_W-1:0] = 12'($urandom_range(0, 10));
			endcase
			apply_settings(lo, hi, len_word, lim_word);
			in_idle  = ($urandom_range(0, 3) != 0);
			out_idle = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(5, 10)) send_random_body();
		end
	endtask

	// ------------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------------

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_form_field_value_extractor_core: errors");
		$finish;
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed_cases();
		test_backpressure();
		test_random_bodies();
		wait_for_quiet();
		$display("summary: %0d body bytes in, %0d value bytes and %0d body ends checked",
			items_sent, value_bytes_seen, finals_seen);
		$display("summary: key found in %0d bodies, %0d mismatches", found_finals, mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb_form_field_value_extractor_core: clean");
		end else begin
			$display("tb_form_field_value_extractor_core: errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/ffve_pkg.sv
rtl/core/ffve_cfg.sv
rtl/core/ffve_step.sv
rtl/core/form_field_value_extractor_core.sv
tb/tb_form_field_value_extractor_core.sv
